/* src/bpru_pkg.sv */
package bpru_pkg;

    localparam int DEF_MAX_WIDTH     = 4096;
    localparam int DEF_MAX_HEIGHT    = 4096;
    localparam int DEF_PALETTE_DEPTH = 256;

    localparam int BYTE_W     = 8;
    localparam int WORD_W     = 32;
    localparam int PIDX_W     = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam int FMT_W      = 2;
    localparam int DIM_W      = 13;
    localparam int DIM_CMP_W  = 18;

    localparam logic CMD_PAL_WRITE = 1'b0;
    localparam logic CMD_PIXEL     = 1'b1;

    localparam logic [FMT_W-1:0] FMT_PAL   = 2'd0;
    localparam logic [FMT_W-1:0] FMT_RGB24 = 2'd1;
    localparam logic [FMT_W-1:0] FMT_RGB32 = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_FORMAT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;

    typedef logic [1:0] t_phase;

endpackage

/* src/bpru_in_if.sv */
interface bpru_in_if
    import bpru_pkg::*;
    ;
    logic              valid;
    logic              ready;
    logic              command;
    logic [BYTE_W-1:0] data_byte;
    logic [PIDX_W-1:0] palette_index;
    logic [WORD_W-1:0] palette_word;

    modport source (
        output valid, command, data_byte, palette_index, palette_word,
        input  ready
    );
    modport sink (
        input  valid, command, data_byte, palette_index, palette_word,
        output ready
    );
endinterface

/* src/bpru_out_if.sv */
interface bpru_out_if
    import bpru_pkg::*;
    ;
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] pixel_word;
    logic              row_end;
    logic              image_end;

    modport source (
        output valid, pixel_word, row_end, image_end,
        input  ready
    );
    modport sink (
        input  valid, pixel_word, row_end, image_end,
        output ready
    );
endinterface

/* src/bmp_pixel_row_unpacker.sv */
// Bitmap pixel row unpacker.
// Input channel i_pix: one item per cycle while i_pix.ready is high, either a
// palette write (command 0, palette_index/palette_word) or one raw pixel-data
// byte (command 1, data_byte), row padding bytes included. Output channel o_pix:
// one 32-bit pixel with row_end and image_end flags, blue in the low byte.
// Configuration (format, width, height) is written through i_cfg_we/idx/data by
// the user only while no item is in flight; the block does not enforce this.
// A byte that completes a pixel passes the input register with the palette
// read, then the output register, before it shows on o_pix. One input item is
// taken per cycle while i_pix.ready is high; 8 bpp gives one pixel per byte,
// 24 bpp one per three bytes, 32 bpp one per four. Padding bytes and palette
// writes give no pixel. The palette is one RAM, written or read once per cycle.
// Reset clears the counters, byte gathering and padding state and sets the
// format to 24 bpp and the size to 1 x 1; palette contents are kept and are
// undefined until written.
// When o_pix stalls the pixel waits in the output register; items that give no
// pixel keep flowing, the next item that completes a pixel waits in the input
// register and i_pix.ready drops until the output register is free.
module bmp_pixel_row_unpacker
    import bpru_pkg::*;
#(
    parameter int MAX_WIDTH     = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT    = DEF_MAX_HEIGHT,
    parameter int PALETTE_DEPTH = DEF_PALETTE_DEPTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    bpru_in_if.sink               i_pix,
    bpru_out_if.source            o_pix,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);
    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int AW = $clog2(PALETTE_DEPTH);

    // configuration
    logic [FMT_W-1:0] r_fmt;
    logic [DIM_W-1:0] r_width;
    logic [DIM_W-1:0] r_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt    <= FMT_RGB24;
            r_width  <= DIM_W'(1);
            r_height <= DIM_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_FORMAT: r_fmt    <= i_cfg_data[FMT_W-1:0];
                REG_WIDTH:  r_width  <= i_cfg_data[DIM_W-1:0];
                REG_HEIGHT: r_height <= i_cfg_data[DIM_W-1:0];
                default: ;
            endcase
        end
    end

    // input register and palette
    logic              accept;
    logic              s1_go;
    logic              r_s1_valid;
    logic              r_s1_cmd;
    logic              r_s1_hit;
    logic              pal_we;
    logic              idx_ok;
    logic              byte_ok;
    logic [WORD_W-1:0] pal_rdata;

    assign accept      = i_pix.valid && i_pix.ready;
    assign i_pix.ready = !r_s1_valid || s1_go;
    assign idx_ok      = {1'b0, i_pix.palette_index} < (PIDX_W + 1)'(PALETTE_DEPTH);
    assign byte_ok     = {1'b0, i_pix.data_byte} < (BYTE_W + 1)'(PALETTE_DEPTH);
    assign pal_we      = accept && (i_pix.command == CMD_PAL_WRITE) && idx_ok;

    bpru_ram #(
        .WIDTH (WORD_W),
        .DEPTH (PALETTE_DEPTH)
    ) u_palette (
        .i_clk   (i_clk),
        .i_we    (pal_we),
        .i_waddr (AW'(i_pix.palette_index)),
        .i_wdata (i_pix.palette_word),
        .i_re    (accept && (i_pix.command == CMD_PIXEL)),
        .i_raddr (AW'(i_pix.data_byte)),
        .o_rdata (pal_rdata)
    );

    logic [BYTE_W-1:0] r_s1_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_pix.ready) begin
            r_s1_valid <= i_pix.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_cmd  <= i_pix.command;
            r_s1_byte <= i_pix.data_byte;
            r_s1_hit  <= byte_ok;
        end
    end

    // unpacking state
    t_phase             r_phase, n_phase;
    logic [23:0]        r_partial, n_partial;
    logic [CW-1:0]      r_col, n_col;
    logic [RW-1:0]      r_row, n_row;
    logic [1:0]         r_pad, n_pad;

    logic               out_free;
    logic               r_out_valid;
    logic [WORD_W-1:0]  r_out_word;
    logic               r_out_row_end;
    logic               r_out_image_end;

    logic               fmt_pal, fmt_24, gather, res_valid, row_end, image_end;
    logic [WORD_W-1:0]  pixel;
    logic [CW-1:0]      w_m1;
    logic [RW-1:0]      h_m1;
    logic [1:0]         wl, pad_new;

    assign out_free = !r_out_valid || o_pix.ready;
    assign fmt_pal  = (r_fmt == FMT_PAL);
    assign fmt_24   = (r_fmt == FMT_RGB24);

    always_comb begin
        if (r_width == '0) begin
            w_m1 = '0;
        end else if (DIM_CMP_W'(r_width) > DIM_CMP_W'(MAX_WIDTH)) begin
            w_m1 = CW'(MAX_WIDTH - 1);
        end else begin
            w_m1 = CW'(r_width - DIM_W'(1));
        end
        if (r_height == '0) begin
            h_m1 = '0;
        end else if (DIM_CMP_W'(r_height) > DIM_CMP_W'(MAX_HEIGHT)) begin
            h_m1 = RW'(MAX_HEIGHT - 1);
        end else begin
            h_m1 = RW'(r_height - DIM_W'(1));
        end
    end

    assign wl = 2'(w_m1) + 2'd1;

    always_comb begin
        pad_new = 2'd0;
        if (fmt_pal) begin
            pad_new = 2'd0 - wl;
        end else if (fmt_24) begin
            pad_new = wl;
        end
    end

    assign gather    = !fmt_pal && (r_phase < (fmt_24 ? 2'd2 : 2'd3));
    assign res_valid = (r_s1_cmd == CMD_PIXEL) && (r_pad == 2'd0) && !gather;
    assign s1_go     = r_s1_valid && (!res_valid || out_free);
    assign row_end   = (r_col >= w_m1);
    assign image_end = row_end && (r_row >= h_m1);

    always_comb begin
        if (fmt_pal) begin
            pixel = r_s1_hit ? pal_rdata : '0;
        end else if (fmt_24) begin
            pixel = {8'h00, r_partial[23:16] | r_s1_byte, r_partial[15:0]};
        end else begin
            pixel = {r_s1_byte, r_partial};
        end
    end

    always_comb begin
        n_phase   = r_phase;
        n_partial = r_partial;
        n_col     = r_col;
        n_row     = r_row;
        n_pad     = r_pad;
        if (s1_go && (r_s1_cmd == CMD_PIXEL)) begin
            if (r_pad != 2'd0) begin
                n_pad = r_pad - 2'd1;
            end else if (gather) begin
                n_phase = r_phase + 2'd1;
                case (r_phase)
                    2'd0:    n_partial = r_partial | {16'h0000, r_s1_byte};
                    2'd1:    n_partial = r_partial | {8'h00, r_s1_byte, 8'h00};
                    2'd2:    n_partial = r_partial | {r_s1_byte, 16'h0000};
                    default: n_partial = r_partial;
                endcase
            end else begin
                n_phase   = '0;
                n_partial = '0;
                if (row_end) begin
                    n_pad = pad_new;
                    n_col = '0;
                    n_row = image_end ? '0 : r_row + RW'(1);
                end else begin
                    n_col = r_col + CW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= '0;
            r_partial <= '0;
            r_col     <= '0;
            r_row     <= '0;
            r_pad     <= '0;
        end else begin
            r_phase   <= n_phase;
            r_partial <= n_partial;
            r_col     <= n_col;
            r_row     <= n_row;
            r_pad     <= n_pad;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= s1_go && res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go && res_valid) begin
            r_out_word      <= pixel;
            r_out_row_end   <= row_end;
            r_out_image_end <= image_end;
        end
    end

    assign o_pix.valid      = r_out_valid;
    assign o_pix.pixel_word = r_out_word;
    assign o_pix.row_end    = r_out_row_end;
    assign o_pix.image_end  = r_out_image_end;

    a_image_end_on_row_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_image_end |-> r_out_row_end)
        else $error("image end without row end");

    a_row_end_clears_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_go && res_valid && row_end |=> r_col == '0 && r_phase == '0)
        else $error("column or phase not cleared at row end");

    a_pad_consumed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_go && (r_s1_cmd == CMD_PIXEL) && (r_pad != 2'd0)
        |=> r_pad == $past(r_pad) - 2'd1 && $stable(r_col))
        else $error("padding byte not skipped");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !o_pix.ready && r_s1_valid && res_valid |=> !$past(s1_go))
        else $error("input stage advanced into a full output register");
endmodule

/* src/bpru_ram.sv */
module bpru_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

/* tb/bmp_pixel_row_unpacker_tb.sv */
`timescale 1ns / 1ps

module bmp_pixel_row_unpacker_tb;
    import bpru_pkg::*;

    localparam logic [FMT_W-1:0] FMT_RGB32_ALT = 2'd3;
    localparam int unsigned RANDOM_ITEMS = 950;

    typedef struct packed {
        logic              command;
        logic [BYTE_W-1:0] data_byte;
        logic [PIDX_W-1:0] palette_index;
        logic [WORD_W-1:0] palette_word;
    } t_pix_item;

    typedef struct packed {
        logic [WORD_W-1:0] pixel_word;
        logic              row_end;
        logic              image_end;
    } t_pixel;

    typedef enum logic {ROW_ITEM, ROW_CFG} t_row_kind;

    typedef struct packed {
        t_row_kind             kind;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] reg_val;
        t_pix_item             item;
        logic                  has_want;
        t_pixel                want;
    } t_dir_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    bpru_in_if  pix_in ();
    bpru_out_if pix_out ();

    bmp_pixel_row_unpacker u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_pix      (pix_in),
        .o_pix      (pix_out),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    // predictor state
    logic [WORD_W-1:0] pal_mem [DEF_PALETTE_DEPTH];
    bit                pal_written [DEF_PALETTE_DEPTH];
    int unsigned       gather_phase;
    logic [23:0]       gathered;
    int unsigned       col_cnt;
    int unsigned       row_cnt;
    int unsigned       pad_left;
    logic [FMT_W-1:0]  cfg_fmt;
    logic [DIM_W-1:0]  cfg_width;
    logic [DIM_W-1:0]  cfg_height;

    t_pixel      pixel_q [$];
    t_pixel      oldest_px;
    t_dir_row    dir_tab [$];
    int unsigned err_cnt;
    int unsigned burst_left;
    int unsigned rand_items;
    int unsigned sink_mode;
    int unsigned sink_span;
    int unsigned sink_tick;
    bit          last_img_end;

    function automatic bit unpack_byte(input t_pix_item it, output t_pixel px);
        int unsigned       bpp;
        int unsigned       w;
        int unsigned       h;
        logic [WORD_W-1:0] word;
        px = '0;
        if (it.command == CMD_PAL_WRITE) begin
            pal_mem[it.palette_index]     = it.palette_word;
            pal_written[it.palette_index] = 1'b1;
            return 1'b0;
        end
        if (pad_left != 0) begin
            pad_left--;
            return 1'b0;
        end
        bpp = (cfg_fmt == FMT_PAL) ? 1 : (cfg_fmt == FMT_RGB24) ? 3 : 4;
        if (bpp == 1) begin
            word = pal_mem[it.data_byte];
        end else if (gather_phase + 1 < bpp) begin
            gathered = gathered | 24'(32'(it.data_byte) << (8 * gather_phase));
            gather_phase++;
            return 1'b0;
        end else begin
            word = {8'h00, gathered} | (32'(it.data_byte) << (8 * (bpp - 1)));
            if (bpp == 3) begin
                word[31:24] = 8'h00;
            end
        end
        gather_phase = 0;
        gathered     = '0;
        w = (cfg_width == 0) ? 1 : (cfg_width > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : cfg_width;
        h = (cfg_height == 0) ? 1 : (cfg_height > DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT : cfg_height;
        px.pixel_word = word;
        px.row_end    = (col_cnt >= w - 1);
        px.image_end  = px.row_end && (row_cnt >= h - 1);
        if (px.row_end) begin
            pad_left = (4 - ((w * bpp) & 3)) & 3;
            col_cnt  = 0;
            row_cnt  = px.image_end ? 0 : row_cnt + 1;
        end else begin
            col_cnt++;
        end
        return 1'b1;
    endfunction

    function automatic t_pix_item rand_item(input logic cmd);
        t_pix_item it;
        it.command       = cmd;
        it.data_byte     = 8'($urandom);
        it.palette_index = 8'($urandom);
        it.palette_word  = $urandom;
        return it;
    endfunction

    function automatic t_dir_row r_pix(input logic [BYTE_W-1:0] b);
        t_dir_row r;
        r                = '0;
        r.kind           = ROW_ITEM;
        r.item.command   = CMD_PIXEL;
        r.item.data_byte = b;
        return r;
    endfunction

    function automatic t_dir_row r_want(input logic [BYTE_W-1:0] b, input logic [WORD_W-1:0] w,
                                        input logic re, input logic ie);
        t_dir_row r;
        r          = r_pix(b);
        r.has_want = 1'b1;
        r.want     = '{w, re, ie};
        return r;
    endfunction

    function automatic t_dir_row r_pal(input logic [PIDX_W-1:0] idx, input logic [WORD_W-1:0] w);
        t_dir_row r;
        r                    = '0;
        r.kind               = ROW_ITEM;
        r.item.command       = CMD_PAL_WRITE;
        r.item.palette_index = idx;
        r.item.palette_word  = w;
        return r;
    endfunction

    function automatic t_dir_row r_cfg(input logic [CFG_IDX_W-1:0] idx,
                                       input logic [CFG_DATA_W-1:0] val);
        t_dir_row r;
        r         = '0;
        r.kind    = ROW_CFG;
        r.reg_idx = idx;
        r.reg_val = val;
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        err_cnt++;
        $display("%0t: %s", $time, msg);
    endtask

    task automatic idle_cycles(input int unsigned n);
        repeat (n) begin
            @(negedge i_clk);
            pix_in.valid = 1'b0;
        end
    endtask

    task automatic settle();
        idle_cycles(1);
        while (pixel_q.size() != 0) begin
            @(negedge i_clk);
        end
        idle_cycles(4);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            REG_FORMAT: cfg_fmt = val[FMT_W-1:0];
            REG_WIDTH:  cfg_width = val;
            REG_HEIGHT: cfg_height = val;
            default: ;
        endcase
    endtask

    task automatic send_item(input t_pix_item it, input bit has_want, input t_pixel want);
        t_pixel px;
        bit     got;
        if (burst_left == 0) begin
            idle_cycles($urandom_range(1, 7));
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        @(negedge i_clk);
        pix_in.valid         = 1'b1;
        pix_in.command       = it.command;
        pix_in.data_byte     = it.data_byte;
        pix_in.palette_index = it.palette_index;
        pix_in.palette_word  = it.palette_word;
        do begin
            @(posedge i_clk);
        end while (!pix_in.ready);
        got = unpack_byte(it, px);
        if (has_want) begin
            px = want;
        end
        if (got || has_want) begin
            pixel_q.push_back(px);
        end
        last_img_end = got && px.image_end;
    endtask

    // pixel bytes with palette writes mixed in; never reads an unwritten entry
    task automatic run_bytes(input int unsigned n, input bit to_image_end);
        int unsigned       k;
        logic [BYTE_W-1:0] b;
        t_pix_item         it;
        k            = 0;
        last_img_end = 1'b0;
        while (k < n || (to_image_end && !last_img_end)) begin
            if ($urandom_range(0, 9) == 0) begin
                send_item(rand_item(CMD_PAL_WRITE), 1'b0, '0);
            end else begin
                b = 8'($urandom);
                if (cfg_fmt == FMT_PAL && pad_left == 0 && !pal_written[b]) begin
                    it               = rand_item(CMD_PAL_WRITE);
                    it.palette_index = b;
                    send_item(it, 1'b0, '0);
                end
                it           = rand_item(CMD_PIXEL);
                it.data_byte = b;
                send_item(it, 1'b0, '0);
            end
            k++;
            rand_items++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && pix_out.valid && pix_out.ready) begin
            if (pixel_q.size() == 0) begin
                report_mismatch($sformatf("pixel %08h with none expected", pix_out.pixel_word));
            end else begin
                oldest_px = pixel_q.pop_front();
                if (pix_out.pixel_word !== oldest_px.pixel_word) begin
                    report_mismatch($sformatf("pixel_word %08h, want %08h",
                                              pix_out.pixel_word, oldest_px.pixel_word));
                end
                if (pix_out.row_end !== oldest_px.row_end) begin
                    report_mismatch($sformatf("row_end %b, want %b",
                                              pix_out.row_end, oldest_px.row_end));
                end
                if (pix_out.image_end !== oldest_px.image_end) begin
                    report_mismatch($sformatf("image_end %b, want %b",
                                              pix_out.image_end, oldest_px.image_end));
                end
            end
        end
    end

    // receiver stall pattern, mode picked at random for each random-length span
    initial begin
        pix_out.ready = 1'b0;
        sink_span     = 0;
        sink_tick     = 0;
        forever begin
            @(negedge i_clk);
            if (sink_span == 0) begin
                sink_mode = $urandom_range(0, 3);
                sink_span = $urandom_range(32, 200);
            end
            sink_span--;
            sink_tick++;
            case (sink_mode)
                0:       pix_out.ready = 1'b1;
                1:       pix_out.ready = ($urandom_range(0, 9) < 7);
                2:       pix_out.ready = (sink_tick % 3 == 0);
                default: pix_out.ready = (sink_tick % 11 < 4);
            endcase
        end
    end

    initial begin
        #2_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        pix_in.valid         = 1'b0;
        pix_in.command       = CMD_PAL_WRITE;
        pix_in.data_byte     = '0;
        pix_in.palette_index = '0;
        pix_in.palette_word  = '0;
        i_cfg_we             = 1'b0;
        i_cfg_idx            = REG_FORMAT;
        i_cfg_data           = '0;
        i_rst_n              = 1'b0;
        cfg_fmt              = FMT_RGB24;
        cfg_width            = 1;
        cfg_height           = 1;
        gather_phase         = 0;
        gathered             = '0;
        col_cnt              = 0;
        row_cnt              = 0;
        pad_left             = 0;
        err_cnt              = 0;
        burst_left           = 0;
        rand_items           = 0;
        last_img_end         = 1'b0;

        dir_tab = '{
            // reset state: 24 bpp, 1 x 1, one padding byte
            r_pix(8'h00), r_pix(8'hFF), r_want(8'h80, 32'h0080_FF00, 1'b1, 1'b1),
            r_pix(8'hAA),
            r_pal(8'h00, 32'hFFFF_FFFF), r_pal(8'h5A, 32'h1234_5678),
            r_pal(8'hFF, 32'hA5C3_0F81),
            r_cfg(REG_FORMAT, CFG_DATA_W'(FMT_PAL)), r_cfg(REG_WIDTH, 13'd3),
            r_cfg(REG_HEIGHT, 13'd2),
            r_want(8'h00, 32'hFFFF_FFFF, 1'b0, 1'b0), r_want(8'hFF, 32'hA5C3_0F81, 1'b0, 1'b0),
            r_want(8'h5A, 32'h1234_5678, 1'b1, 1'b0), r_pix(8'h33),
            r_want(8'hFF, 32'hA5C3_0F81, 1'b0, 1'b0), r_want(8'h00, 32'hFFFF_FFFF, 1'b0, 1'b0),
            r_want(8'h00, 32'hFFFF_FFFF, 1'b1, 1'b1), r_pix(8'h77),
            r_cfg(REG_FORMAT, CFG_DATA_W'(FMT_RGB32)), r_cfg(REG_WIDTH, 13'd1),
            r_cfg(REG_HEIGHT, 13'd1),
            r_pix(8'h01), r_pix(8'h02), r_pix(8'h03), r_want(8'hFE, 32'hFE03_0201, 1'b1, 1'b1),
            // format code 3 and zero sizes
            r_cfg(REG_FORMAT, CFG_DATA_W'(FMT_RGB32_ALT)), r_cfg(REG_WIDTH, 13'd0),
            r_cfg(REG_HEIGHT, 13'd0),
            r_pix(8'hFF), r_pix(8'hFF), r_pix(8'hFF), r_want(8'hFF, 32'hFFFF_FFFF, 1'b1, 1'b1)
        };

        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (dir_tab[i]) begin
            if (dir_tab[i].kind == ROW_CFG) begin
                settle();
                write_reg(dir_tab[i].reg_idx, dir_tab[i].reg_val);
            end else begin
                send_item(dir_tab[i].item, dir_tab[i].has_want, dir_tab[i].want);
            end
        end

        while (rand_items < RANDOM_ITEMS) begin
            settle();
            if ($urandom_range(0, 3) != 0) begin
                write_reg(REG_FORMAT, CFG_DATA_W'($urandom_range(0, 3)));
            end
            if ($urandom_range(0, 2) != 0) begin
                write_reg(REG_WIDTH, CFG_DATA_W'(($urandom_range(0, 15) == 0) ? 0 :
                    ($urandom_range(0, 15) == 0) ? $urandom_range(41, 300) :
                    $urandom_range(1, 12)));
            end
            if ($urandom_range(0, 2) != 0) begin
                write_reg(REG_HEIGHT, CFG_DATA_W'(($urandom_range(0, 15) == 0) ? 0 :
                    $urandom_range(1, 4)));
            end
            run_bytes($urandom_range(10, 120), ($urandom_range(0, 1) == 1) && (cfg_width <= 12));
        end

        // saturated width, then saturated height
        settle();
        write_reg(REG_FORMAT, CFG_DATA_W'(FMT_PAL));
        write_reg(REG_WIDTH, 13'h1FFF);
        write_reg(REG_HEIGHT, 13'd0);
        run_bytes(40, 1'b0);
        settle();
        write_reg(REG_WIDTH, 13'd0);
        write_reg(REG_HEIGHT, 13'h1FFF);
        run_bytes(40, 1'b0);

        // largest size, then shrink mid-image
        settle();
        write_reg(REG_FORMAT, CFG_DATA_W'(FMT_RGB32));
        write_reg(REG_WIDTH, CFG_DATA_W'(DEF_MAX_WIDTH));
        write_reg(REG_HEIGHT, CFG_DATA_W'(DEF_MAX_HEIGHT));
        run_bytes(66, 1'b0);
        settle();
        write_reg(REG_FORMAT, CFG_DATA_W'(FMT_RGB24));
        write_reg(REG_WIDTH, 13'd2);
        write_reg(REG_HEIGHT, 13'd2);
        run_bytes(30, 1'b1);

        settle();
        idle_cycles(6);
        if (err_cnt == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
